// ===== sv/nnfs_pkg.sv =====
// ----------------------------------------------------------------------------
// nnfs_pkg
// Shared sizes, codes and the pipeline word layout of the nearest-neighbor
// frame scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package nnfs_pkg;

  // Source frame geometry.
  localparam int SRC_WIDTH   = 640;
  localparam int SRC_HEIGHT  = 400;
  localparam int STORE_DEPTH = SRC_WIDTH * SRC_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths of the ports.
  localparam int SRC_INDEX_W = 18;
  localparam int COORD_W     = 12;
  localparam int DIM_W       = 13;
  localparam int PITCH_W     = 16;
  localparam int PIXEL_W     = 32;
  localparam int OFFSET_W    = 28;

  // Configuration port.
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // Divider sizing: the scaled coordinate of an in-range fetch is below the source size.
  localparam int QUOT_W      = $clog2((SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT);
  localparam int DIVD_W      = COORD_W + QUOT_W;
  localparam int LIN_W       = 2 * QUOT_W + 1;

  // Pipeline: one setup stage, one stage per quotient bit, one address stage.
  localparam int DIV_STAGES  = QUOT_W;
  localparam int NUM_STG     = DIV_STAGES + 2;

  // Register reset values.
  localparam logic [DIM_W-1:0]   DEST_WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0]   DEST_HEIGHT_RST = DIM_W'(400);
  localparam logic [PITCH_W-1:0] ROW_PITCH_RST   = PITCH_W'(2560);

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_WIDTH  = 2'd0,
    REG_DEST_HEIGHT = 2'd1,
    REG_ROW_PITCH   = 2'd2
  } cfg_reg_t;

  // Input word actions.
  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_FETCH = 1'b1
  } action_t;

  // One word in flight through the pipeline.
  typedef struct packed {
    logic                is_fetch;
    logic                load_ok;
    logic                oor;
    logic [ADDR_W-1:0]   addr;
    logic [PIXEL_W-1:0]  pixel;
    logic [OFFSET_W-1:0] offset;
    logic [DIVD_W-1:0]   rem_x;
    logic [DIVD_W-1:0]   rem_y;
    logic [QUOT_W-1:0]   quot_x;
    logic [QUOT_W-1:0]   quot_y;
  } stage_t;

endpackage

`default_nettype wire

// ===== sv/nearest_neighbor_frame_scaler_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_frame_scaler_unit
// Holds one source frame and answers destination pixel fetches with the
// nearest source pixel and the destination byte offset.
// ----------------------------------------------------------------------------
`default_nettype none

// The block takes one word per clock on the input channel while the output
// does not stall, and returns one result per fetch word. The pipeline holds
// one setup stage (pitch multiply, range check, scaled dividends), ten
// restoring divider stages that produce one quotient bit each for both axes,
// one address stage, and the single-port frame memory (256000 x 32 bits, one
// read or write per clock) whose registered read data forms the output stage.
// Load words travel the same pipeline and write the memory at the point
// where fetches read it, so every fetch sees exactly the loads accepted
// before it. Load words produce no result. The frame memory is not cleared
// at reset; a fetch of a pixel never loaded returns an arbitrary value.
// Configuration writes are meant for idle periods only.
module nearest_neighbor_frame_scaler_unit
  import nnfs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,

  input  wire logic                   cfg_write,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,

  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   action,
  input  wire logic [SRC_INDEX_W-1:0] source_index,
  input  wire logic [PIXEL_W-1:0]     source_pixel,
  input  wire logic [COORD_W-1:0]     dest_x,
  input  wire logic [COORD_W-1:0]     dest_y,

  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [PIXEL_W-1:0]          pixel_out,
  output logic [OFFSET_W-1:0]         byte_offset,
  output logic                        out_of_range
);

  // Configuration registers.
  logic [DIM_W-1:0]    dest_width;
  logic [DIM_W-1:0]    dest_height;
  logic [PITCH_W-1:0]  row_pitch;

  // Pipeline registers and their next values.
  stage_t              stg_q [1:NUM_STG];
  stage_t              stg_d [1:NUM_STG];
  logic [NUM_STG:1]    v;
  logic [NUM_STG:1]    v_prev;
  logic [NUM_STG+1:1]  ld;

  // Setup stage helpers.
  logic [PITCH_W-1:0]  pitch_sel;
  logic [OFFSET_W-1:0] offset_calc;
  logic [LIN_W-1:0]    lin_addr;

  // Frame memory and output stage.
  logic [PIXEL_W-1:0]  frame_mem [STORE_DEPTH];
  logic [PIXEL_W-1:0]  rd_data;
  logic                out_oor;
  logic [OFFSET_W-1:0] out_offset;

  // Register writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      dest_width  <= DEST_WIDTH_RST;
      dest_height <= DEST_HEIGHT_RST;
      row_pitch   <= ROW_PITCH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEST_WIDTH:  dest_width  <= cfg_data[DIM_W-1:0];
        REG_DEST_HEIGHT: dest_height <= cfg_data[DIM_W-1:0];
        REG_ROW_PITCH:   row_pitch   <= cfg_data[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Stall chain: a stage loads when it is empty or its successor loads.
  always_comb begin
    ld[NUM_STG+1] = !out_valid || out_ready;
    for (int s = NUM_STG; s >= 1; s--) begin
      ld[s] = !v[s] || ld[s+1];
    end
  end

  assign in_ready = ld[1];
  assign v_prev   = {v[NUM_STG-1:1], in_valid};

  // A pitch of zero stands for four bytes per destination pixel.
  assign pitch_sel   = (row_pitch == '0) ? PITCH_W'({dest_width, 2'b00}) : row_pitch;
  assign offset_calc = OFFSET_W'(dest_y) * OFFSET_W'(pitch_sel)
                     + OFFSET_W'({dest_x, 2'b00});

  // Linear source address from the two quotients of the last divider stage.
  assign lin_addr = LIN_W'(stg_q[NUM_STG-1].quot_y) * LIN_W'(SRC_WIDTH)
                  + LIN_W'(stg_q[NUM_STG-1].quot_x);

  // Next values of every stage.
  always_comb begin
    // Setup stage: decode the input word.
    stg_d[1].is_fetch = (action == ACT_FETCH);
    stg_d[1].load_ok  = (action == ACT_LOAD) &&
                        (32'(source_index) < 32'(STORE_DEPTH));
    stg_d[1].oor      = ({1'b0, dest_x} >= dest_width) || ({1'b0, dest_y} >= dest_height);
    stg_d[1].addr     = ADDR_W'(source_index);
    stg_d[1].pixel    = source_pixel;
    stg_d[1].offset   = offset_calc;
    stg_d[1].rem_x    = DIVD_W'(dest_x) * DIVD_W'(SRC_WIDTH);
    stg_d[1].rem_y    = DIVD_W'(dest_y) * DIVD_W'(SRC_HEIGHT);
    stg_d[1].quot_x   = '0;
    stg_d[1].quot_y   = '0;

    // Divider stages: each resolves one quotient bit, most significant first.
    for (int k = 1; k <= DIV_STAGES; k++) begin
      stg_d[k+1] = stg_q[k];
      if (stg_q[k].rem_x >= (DIVD_W'(dest_width) << (DIV_STAGES - k))) begin
        stg_d[k+1].rem_x = stg_q[k].rem_x - (DIVD_W'(dest_width) << (DIV_STAGES - k));
        stg_d[k+1].quot_x[DIV_STAGES - k] = 1'b1;
      end
      if (stg_q[k].rem_y >= (DIVD_W'(dest_height) << (DIV_STAGES - k))) begin
        stg_d[k+1].rem_y = stg_q[k].rem_y - (DIVD_W'(dest_height) << (DIV_STAGES - k));
        stg_d[k+1].quot_y[DIV_STAGES - k] = 1'b1;
      end
    end

    // Address stage: fetches point at the nearest source pixel.
    stg_d[NUM_STG] = stg_q[NUM_STG-1];
    if (stg_q[NUM_STG-1].is_fetch) begin
      stg_d[NUM_STG].addr = stg_q[NUM_STG-1].oor ? '0 : lin_addr[ADDR_W-1:0];
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 1; s <= NUM_STG; s++) begin
        if (ld[s]) begin
          v[s] <= v_prev[s];
        end
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    for (int s = 1; s <= NUM_STG; s++) begin
      if (ld[s]) begin
        stg_q[s] <= stg_d[s];
      end
    end
  end

  // Frame memory: one access per clock, read or write, in word order.
  always_ff @(posedge clk) begin
    if (ld[NUM_STG+1] && v[NUM_STG]) begin
      if (stg_q[NUM_STG].is_fetch) begin
        rd_data <= frame_mem[stg_q[NUM_STG].addr];
      end else if (stg_q[NUM_STG].load_ok) begin
        frame_mem[stg_q[NUM_STG].addr] <= stg_q[NUM_STG].pixel;
      end
    end
  end

  // Output stage valid; only fetches produce a result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld[NUM_STG+1]) begin
      out_valid <= v[NUM_STG] && stg_q[NUM_STG].is_fetch;
    end
  end

  // Output stage payload.
  always_ff @(posedge clk) begin
    if (ld[NUM_STG+1] && v[NUM_STG]) begin
      out_oor    <= stg_q[NUM_STG].oor;
      out_offset <= stg_q[NUM_STG].offset;
    end
  end

  assign pixel_out    = out_oor ? '0 : rd_data;
  assign byte_offset  = out_offset;
  assign out_of_range = out_oor;

  // The input side stalls only when every stage and the output are full.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> ((&v) && out_valid))
    else $error("input stalled with room in the pipeline");

  // An in-range fetch leaves the divider with quotients inside the source frame.
  a_quot_in_frame: assert property (@(posedge clk) disable iff (rst)
    (v[NUM_STG-1] && stg_q[NUM_STG-1].is_fetch && !stg_q[NUM_STG-1].oor) |->
    ((32'(stg_q[NUM_STG-1].quot_x) < 32'(SRC_WIDTH)) &&
     (32'(stg_q[NUM_STG-1].quot_y) < 32'(SRC_HEIGHT))))
    else $error("scaled position outside the source frame");

  // Every fetch presented to the memory addresses a real entry.
  a_fetch_addr_in_store: assert property (@(posedge clk) disable iff (rst)
    (v[NUM_STG] && stg_q[NUM_STG].is_fetch) |->
    (32'(stg_q[NUM_STG].addr) < 32'(STORE_DEPTH)))
    else $error("fetch address beyond the frame memory");

  // A new result word comes only from a fetch that left the address stage.
  a_result_from_fetch: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(v[NUM_STG] && stg_q[NUM_STG].is_fetch && ld[NUM_STG+1]))
    else $error("result word without a fetch");

endmodule

`default_nettype wire
